// ----- hw/rtl/jdcm_pkg.sv -----
// Shared types and constants for the joystick dead-zone calibrate and map unit.
package jdcm_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned QuotW   = 7;
  localparam int unsigned NumW    = SampleW + QuotW;
  localparam int unsigned AngleW  = 8;
  localparam int unsigned CntW    = 10;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned BtnN    = 4;
  localparam int unsigned InW     = 32;
  localparam int unsigned OutW    = 24;

  localparam logic [SampleW-1:0] AdcFull      = 12'd4095;
  localparam logic [QuotW-1:0]   XScale       = 7'd89;
  localparam logic [QuotW-1:0]   YScale       = 7'd90;
  localparam logic [AngleW-1:0]  XCenter      = 8'd90;
  localparam logic [AngleW-1:0]  XAboveOffset = 8'd91;
  localparam logic [AngleW-1:0]  YBelowOffset = 8'd90;

  typedef enum logic [1:0] {
    REG_INSIDE,
    REG_BELOW,
    REG_ABOVE
  } region_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               cal;
    logic               cal_first;
    logic               start;
    logic               step;
    logic [BitIdxW-1:0] bit_idx;
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/jdcm_lane.sv -----
// One axis lane: dead-zone bounds tracking and a restoring divider for the mapping.
module jdcm_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jdcm_pkg::lane_ctrl_t          ctrl_i,
  input  logic [jdcm_pkg::SampleW-1:0]  sample_i,
  input  logic [jdcm_pkg::QuotW-1:0]    scale_i,
  output jdcm_pkg::region_e             region_o,
  output logic [jdcm_pkg::QuotW-1:0]    quot_o
);
  import jdcm_pkg::*;

  logic [SampleW-1:0] low_q, low_d, high_q, high_d;
  region_e            region_q, region_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [SampleW-1:0] den_q, den_d;
  logic [QuotW-1:0]   quot_q, quot_d;

  logic               below, above;
  logic [SampleW-1:0] mul_in;
  logic [NumW-1:0]    shifted;

  assign below   = sample_i < low_q;
  assign above   = sample_i > high_q;
  assign mul_in  = below ? sample_i : sample_i - high_q;
  assign shifted = NumW'(den_q) << ctrl_i.bit_idx;

  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    region_d = region_q;
    num_d    = num_q;
    den_d    = den_q;
    quot_d   = quot_q;
    if (ctrl_i.cal) begin
      if (ctrl_i.cal_first) begin
        low_d  = sample_i;
        high_d = sample_i;
      end else begin
        if (below) low_d = sample_i;
        if (above) high_d = sample_i;
      end
    end
    if (ctrl_i.start) begin
      // register the product before the divide loop
      num_d    = NumW'(mul_in) * NumW'(scale_i);
      den_d    = below ? low_q : AdcFull - high_q;
      quot_d   = '0;
      region_d = below ? REG_BELOW : (above ? REG_ABOVE : REG_INSIDE);
    end
    if (ctrl_i.step && (num_q >= shifted)) begin
      num_d                  = num_q - shifted;
      quot_d[ctrl_i.bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      region_q <= REG_INSIDE;
    end else begin
      low_q    <= low_d;
      high_q   <= high_d;
      region_q <= region_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign region_o = region_q;
  assign quot_o   = quot_q;

endmodule

// ----- hw/rtl/jdcm_merge.sv -----
// Merge stage: turns lane quotients into angles and holds the output word.
module jdcm_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  jdcm_pkg::region_e             x_region_i,
  input  logic [jdcm_pkg::QuotW-1:0]    x_quot_i,
  input  jdcm_pkg::region_e             y_region_i,
  input  logic [jdcm_pkg::QuotW-1:0]    y_quot_i,
  input  logic [jdcm_pkg::BtnN-1:0]     btn_raw_i,
  input  logic                          m_axis_tready_i,
  output logic                          m_axis_tvalid_o,
  output logic [jdcm_pkg::OutW-1:0]     m_axis_tdata_o
);
  import jdcm_pkg::*;

  logic                     valid_q, valid_d;
  logic [OutW-1:0]          data_q, data_d;
  logic [AngleW-1:0]        x_angle;
  logic signed [AngleW-1:0] y_angle;

  always_comb begin
    case (x_region_i)
      REG_BELOW: x_angle = AngleW'(x_quot_i);
      REG_ABOVE: x_angle = AngleW'(x_quot_i) + XAboveOffset;
      default:   x_angle = XCenter;
    endcase
  end

  always_comb begin
    case (y_region_i)
      REG_BELOW: y_angle = AngleW'(y_quot_i) - YBelowOffset;
      REG_ABOVE: y_angle = AngleW'(y_quot_i);
      default:   y_angle = '0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (m_axis_tready_i) valid_d = 1'b0;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = {4'b0000, ~btn_raw_i, y_angle, x_angle};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// ----- hw/rtl/joystick_deadzone_calibrate_map_unit.sv -----
// Top level of the joystick dead-zone calibrate and map unit.
//
//  channel  dir  handshake                        payload
//  s_axis   in   s_axis_tvalid_i/s_axis_tready_o  x, y samples and four raw buttons
//  m_axis   out  m_axis_tvalid_o/m_axis_tready_i  x, y angles and four pressed flags
//
// A calibration word gives no output word.
// A mapped word registers the scaled sample, runs seven restoring divide
// steps in the two axis lanes, then loads the output register once it is free.
// A waiting output word stalls the unit only once the next word has finished.
// rst_ni clears the calibration counter and the controller; no clearing pass.
module joystick_deadzone_calibrate_map_unit #(
  parameter int unsigned CAL_SAMPLES = 1000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [11:0] x_sample, [23:12] y_sample, [24] button_a_raw, [25] button_b_raw,
  // [26] button_c_raw, [27] button_d_raw, [31:28] zero
  input  logic [jdcm_pkg::InW-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] x_angle, [15:8] y_angle, [16] button_a_pressed, [17] button_b_pressed,
  // [18] button_c_pressed, [19] button_d_pressed, [23:20] zero
  output logic [jdcm_pkg::OutW-1:0]  m_axis_tdata_o
);
  import jdcm_pkg::*;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [BtnN-1:0]    btn_q, btn_d;

  logic               accept, cal_done, out_free, load;
  lane_ctrl_t         ctrl;
  region_e            x_region, y_region;
  logic [QuotW-1:0]   x_quot, y_quot;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign cal_done = cnt_q == CntW'(CAL_SAMPLES);
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && cal_done) state_d = ST_DIV;
      ST_DIV:  if (bit_q == '0) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = state_q == ST_IDLE;
    ctrl.cal        = accept && !cal_done;
    ctrl.cal_first  = cnt_q == '0;
    ctrl.start      = accept && cal_done;
    ctrl.step       = state_q == ST_DIV;
    ctrl.bit_idx    = bit_q;
    load            = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    cnt_d = cnt_q;
    bit_d = bit_q;
    btn_d = btn_q;
    if (ctrl.cal) cnt_d = cnt_q + 1'b1;
    if (ctrl.start) begin
      bit_d = BitIdxW'(QuotW - 1);
      btn_d = s_axis_tdata_i[27:24];
    end else if (ctrl.step) begin
      bit_d = bit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    btn_q <= btn_d;
  end

  jdcm_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s_axis_tdata_i[11:0]),
    .scale_i  (XScale),
    .region_o (x_region),
    .quot_o   (x_quot)
  );

  jdcm_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s_axis_tdata_i[23:12]),
    .scale_i  (YScale),
    .region_o (y_region),
    .quot_o   (y_quot)
  );

  jdcm_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .x_region_i      (x_region),
    .x_quot_i        (x_quot),
    .y_region_i      (y_region),
    .y_quot_i        (y_quot),
    .btn_raw_i       (btn_q),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- hw/rtl/jdcm_checker.sv -----
// Port-level checks for the joystick dead-zone calibrate and map unit.
module jdcm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [jdcm_pkg::OutW-1:0] m_axis_tdata_o
);
  import jdcm_pkg::*;

  // hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output word changed");

  // a new output word comes only from the finish cycle, when input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("output word appeared without a finished divide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:0] <= 8'd180)
      && ($signed(m_axis_tdata_o[15:8]) >= -90)
      && ($signed(m_axis_tdata_o[15:8]) <= 90)
      && (m_axis_tdata_o[23:20] == 4'b0000))
    else $error("output angle out of range");

endmodule

bind joystick_deadzone_calibrate_map_unit jdcm_checker u_jdcm_checker (.*);

// ----- dv/joystick_deadzone_calibrate_map_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the joystick dead-zone calibrate and map unit.
module joystick_deadzone_calibrate_map_unit_tb;
  import jdcm_pkg::*;

  localparam int unsigned CalWords    = 1000;
  localparam int unsigned FullScale   = 4095;
  localparam int unsigned XSteps      = 89;
  localparam int unsigned XUpperBase  = 91;
  localparam int unsigned XMid        = 90;
  localparam int unsigned YSteps      = 90;
  // Calibration window; the seeding rows hit both ends of each axis exactly.
  localparam int          XLo         = 1500;
  localparam int          XHi         = 2500;
  localparam int          YLo         = 1800;
  localparam int          YHi         = 2200;
  localparam int unsigned RandWords   = 630;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 24;

  typedef struct packed {
    logic [3:0]        pressed;  // d c b a
    logic signed [7:0] y_angle;
    logic [7:0]        x_angle;
  } joy_angles_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  btn_raw;
    logic        typed;
    joy_angles_t want;
  } map_row_t;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  // [11:0] x_sample, [23:12] y_sample, [27:24] button_a..d_raw, [31:28] zero
  logic [InW-1:0]    s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  // [7:0] x_angle, [15:8] y_angle, [19:16] button_a..d_pressed, [23:20] zero
  logic [OutW-1:0]   m_axis_tdata_o;

  joystick_deadzone_calibrate_map_unit #(
    .CAL_SAMPLES(CalWords)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Predictor state
  int unsigned cal_seen = 0;
  logic [11:0] x_lo = '0, x_hi = '0, y_lo = '0, y_hi = '0;

  joy_angles_t angles_due[$];
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          hold_rx      = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned err_count    = 0;
  int unsigned cal_sent     = 0;
  int unsigned mapped_sent  = 0;
  int unsigned angles_seen  = 0;
  int unsigned quiet_cycles = 0;

  string btn_field [4] = '{"button_a_pressed", "button_b_pressed",
                           "button_c_pressed", "button_d_pressed"};

  // First sample sits mid-window so a bound stuck at its reset value shows up.
  logic [11:0] cal_seed_x [4] = '{12'd2000, 12'd1500, 12'd2500, 12'd2100};
  logic [11:0] cal_seed_y [4] = '{12'd2000, 12'd2200, 12'd1800, 12'd1900};

  map_row_t map_rows [15] = '{
    '{12'd0,    12'd0,    4'b1111, 1'b1, '{4'b0000, -8'sd90, 8'd0}},
    '{12'd4095, 12'd4095, 4'b0000, 1'b1, '{4'b1111,  8'sd90, 8'd180}},
    '{12'd2000, 12'd2000, 4'b1010, 1'b1, '{4'b0101,  8'sd0,  8'd90}},
    '{12'd1500, 12'd1800, 4'b0101, 1'b1, '{4'b1010,  8'sd0,  8'd90}},
    '{12'd2500, 12'd2200, 4'b1100, 1'b1, '{4'b0011,  8'sd0,  8'd90}},
    '{12'd0,    12'd4095, 4'b0011, 1'b1, '{4'b1100,  8'sd90, 8'd0}},
    '{12'd4095, 12'd0,    4'b1001, 1'b1, '{4'b0110, -8'sd90, 8'd180}},
    '{12'd2000, 12'd0,    4'b0110, 1'b1, '{4'b1001, -8'sd90, 8'd90}},
    '{12'd0,    12'd2000, 4'b1110, 1'b1, '{4'b0001,  8'sd0,  8'd0}},
    '{12'd1499, 12'd1799, 4'b0111, 1'b0, '0},
    '{12'd2501, 12'd2201, 4'b1011, 1'b0, '0},
    '{12'd1,    12'd1,    4'b1101, 1'b0, '0},
    '{12'd4094, 12'd4094, 4'b0001, 1'b0, '0},
    '{12'd750,  12'd900,  4'b0010, 1'b0, '0},
    '{12'd3300, 12'd3100, 4'b0100, 1'b0, '0}
  };

  // Track bounds during calibration, else map the sample to angles.
  function automatic bit track_or_map_sample(input logic [InW-1:0] word,
                                             output joy_angles_t angles);
    int unsigned x, y;
    int          ya;
    x = 32'(word[11:0]);
    y = 32'(word[23:12]);
    angles = '0;
    if (cal_seen < CalWords) begin
      if (cal_seen == 0) begin
        x_lo = 12'(x); x_hi = 12'(x); y_lo = 12'(y); y_hi = 12'(y);
      end else begin
        if (x > x_hi) x_hi = 12'(x);
        if (x < x_lo) x_lo = 12'(x);
        if (y > y_hi) y_hi = 12'(y);
        if (y < y_lo) y_lo = 12'(y);
      end
      cal_seen++;
      return 1'b0;
    end
    if (x < x_lo) angles.x_angle = 8'((x * XSteps) / x_lo);
    else if (x > x_hi) angles.x_angle = 8'(((x - x_hi) * XSteps) / (FullScale - x_hi) + XUpperBase);
    else angles.x_angle = 8'(XMid);
    if (y < y_lo) ya = int'((y * YSteps) / y_lo) - int'(YSteps);
    else if (y > y_hi) ya = int'(((y - y_hi) * YSteps) / (FullScale - y_hi));
    else ya = 0;
    angles.y_angle = 8'(ya);
    angles.pressed = ~word[27:24];
    return 1'b1;
  endfunction

  // Bias samples toward each region and the edges of the dead zone.
  function automatic logic [11:0] pick_sample(input int lo, input int hi);
    case ($urandom_range(5))
      0: return 12'($urandom_range(lo - 1, 0));
      1: return 12'($urandom_range(hi, lo));
      2: return 12'($urandom_range(FullScale, hi + 1));
      3: return 12'($urandom_range(lo + 2, lo - 2));
      4: return 12'($urandom_range(hi + 2, hi - 2));
      default: return 12'($urandom_range(FullScale, 0));
    endcase
  endfunction

  task automatic offer_word(input logic [11:0] x, input logic [11:0] y,
                            input logic [3:0] btn_raw, input logic typed,
                            input joy_angles_t typed_want);
    joy_angles_t    angles;
    logic [InW-1:0] word;
    word = {4'b0000, btn_raw, y, x};
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (track_or_map_sample(word, angles)) begin
      angles_due.push_back(typed ? typed_want : angles);
      mapped_sent++;
    end else begin
      cal_sent++;
    end
  endtask

  // Hold the input side until every expected word is back.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (angles_due.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    tx_idle_pct = 28;
    rx_idle_pct = 47;
    for (int i = 0; i < 4; i++)
      offer_word(cal_seed_x[i], cal_seed_y[i], 4'($urandom_range(15)), 1'b0, '0);
    for (int i = 4; i < CalWords; i++)
      offer_word(12'($urandom_range(XHi, XLo)), 12'($urandom_range(YHi, YLo)),
                 4'($urandom_range(15)), 1'b0, '0);
    foreach (map_rows[i])
      offer_word(map_rows[i].x, map_rows[i].y, map_rows[i].btn_raw,
                 map_rows[i].typed, map_rows[i].want);
    wait_drained();
    for (int i = 0; i < RandWords; i++) begin
      if (i == RandWords / 3) begin
        wait_drained();
        tx_idle_pct = 47;
        rx_idle_pct = 28;
      end
      if (i == 2 * RandWords / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_rx     = 1'b1;
      end
      offer_word(pick_sample(XLo, XHi), pick_sample(YLo, YHi),
                 4'($urandom_range(15)), 1'b0, '0);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (angles_due.size() != 0) begin
      $error("%0d expected words never arrived", angles_due.size());
    end
    $display("Fed %0d calibration words and %0d mapped words; checked %0d output words",
             cal_sent, mapped_sent, angles_seen);
    $display("Covered dead-zone edges, axis extremes, all button patterns and a long output hold");
    if (err_count == 0 && angles_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold while input keeps coming.
  initial begin : receiver
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rx && !hold_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_angles
    joy_angles_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[19:0];
      angles_seen++;
      if (angles_due.size() == 0) begin
        $error("output word %h with nothing expected", m_axis_tdata_o);
        err_count++;
      end else begin
        want = angles_due.pop_front();
        if (got.x_angle !== want.x_angle) begin
          $error("x_angle: expected %0d, got %0d", want.x_angle, got.x_angle);
          err_count++;
        end
        if (got.y_angle !== want.y_angle) begin
          $error("y_angle: expected %0d, got %0d", want.y_angle, got.y_angle);
          err_count++;
        end
        for (int b = 0; b < 4; b++) begin
          if (got.pressed[b] !== want.pressed[b]) begin
            $error("%s: expected %0b, got %0b", btn_field[b], want.pressed[b],
                   got.pressed[b]);
            err_count++;
          end
        end
      end
    end
  end

  // Stop a hung run: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

endmodule

// ----- joystick_deadzone_calibrate_map_unit.f -----
hw/rtl/jdcm_pkg.sv
hw/rtl/jdcm_lane.sv
hw/rtl/jdcm_merge.sv
hw/rtl/joystick_deadzone_calibrate_map_unit.sv
hw/rtl/jdcm_checker.sv
dv/joystick_deadzone_calibrate_map_unit_tb.sv
